// ===== rtl/two_choice_bucket_hash_table_unit_assert.svh =====
// Assertion macros shared by the hash table RTL.
`ifndef TWO_CHOICE_BUCKET_HASH_TABLE_UNIT_ASSERT_SVH
`define TWO_CHOICE_BUCKET_HASH_TABLE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCBH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCBH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tcbh_pkg.sv =====
// Shared constants and types of the two-choice bucket hash table.
package tcbh_pkg;

	localparam int NUM_BUCKETS_DEF  = 256;
	localparam int BUCKET_SLOTS_DEF = 4;
	localparam int KEY_W            = 64;
	localparam int VAL_W            = 64;
	localparam int TOTAL_W          = 32;
	localparam int CFG_W            = 9;

	localparam logic [CFG_W-1:0] NBKT_RST = 9'd256;

	localparam logic [63:0] FMIX_C1    = 64'hFF51AFD7ED558CCD;
	localparam logic [63:0] FMIX_C2    = 64'hC4CEB9FE1A85EC53;
	localparam int          FMIX_SHIFT = 33;

	localparam logic FUNC_LOOKUP = 1'b0;
	localparam logic FUNC_INSERT = 1'b1;

	localparam logic REG_NBKT = 1'b0;

	typedef enum logic [2:0] {
		ST_MISS    = 3'd0,
		ST_HIT     = 3'd1,
		ST_UPDATED = 3'd2,
		ST_PLACED  = 3'd3,
		ST_DROPPED = 3'd4
	} status_t;

endpackage

// ===== rtl/tcbh_ram.sv =====
// Generic single-port RAM with a registered read.
module tcbh_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic [AW-1:0]    addr,
	input  logic             we,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== rtl/tcbh_hash.sv =====
// Bucket hash unit: two fmix64 rounds and two range reductions on one shared multiplier.
module tcbh_hash import tcbh_pkg::*; #(
	parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
	localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1,
	localparam int NW = $clog2(NUM_BUCKETS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] key,
	input  logic [NW-1:0]    n,
	output logic             done,
	output logic [BW-1:0]    bkt_a,
	output logic [BW-1:0]    bkt_b
);

	typedef enum logic [3:0] {
		H_IDLE, H_M1A, H_M1B, H_M1C, H_X1, H_M2A, H_M2B, H_M2C, H_X2,
		H_RALO, H_RAHI, H_RBLO, H_RBHI, H_ADJ
	} hstate_t;

	hstate_t     state_q;
	logic        pass_q;
	logic        done_q;
	logic [63:0] key_q;
	logic [NW-1:0] n_q;
	logic [63:0] x_q;
	logic [63:0] acc_q;
	logic [63:0] mix_a_q;
	logic [BW-1:0] ba_q;
	logic [BW-1:0] bb_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [63:0] acc_mix;
	logic [63:0] y;
	logic [63:0] y_pre;
	logic [63:0] mid;
	logic        ba_last;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			H_M1A: begin mul_a = x_q[31:0];      mul_b = FMIX_C1[31:0];  end
			H_M1B: begin mul_a = x_q[63:32];     mul_b = FMIX_C1[31:0];  end
			H_M1C: begin mul_a = x_q[31:0];      mul_b = FMIX_C1[63:32]; end
			H_M2A: begin mul_a = x_q[31:0];      mul_b = FMIX_C2[31:0];  end
			H_M2B: begin mul_a = x_q[63:32];     mul_b = FMIX_C2[31:0];  end
			H_M2C: begin mul_a = x_q[31:0];      mul_b = FMIX_C2[63:32]; end
			H_RALO: begin mul_a = mix_a_q[31:0];  mul_b = 32'(n_q); end
			H_RAHI: begin mul_a = mix_a_q[63:32]; mul_b = 32'(n_q); end
			H_RBLO: begin mul_a = x_q[31:0];      mul_b = 32'(n_q); end
			H_RBHI: begin mul_a = x_q[63:32];     mul_b = 32'(n_q); end
			default: ;
		endcase
	end

	assign prod    = {32'b0, mul_a} * {32'b0, mul_b};
	assign acc_mix = acc_q ^ (acc_q >> FMIX_SHIFT);
	assign y       = key_q ^ acc_mix;
	assign y_pre   = y ^ (y >> FMIX_SHIFT);
	assign mid     = prod + (acc_q >> 32);
	assign ba_last = (32'(ba_q) == (32'(n_q) - 32'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			pass_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				H_IDLE: begin
					if (start) begin
						key_q   <= key;
						n_q     <= n;
						x_q     <= key ^ (key >> FMIX_SHIFT);
						pass_q  <= 1'b0;
						state_q <= H_M1A;
					end
				end
				H_M1A: begin
					acc_q   <= prod;
					state_q <= H_M1B;
				end
				H_M1B: begin
					acc_q   <= acc_q + {prod[31:0], 32'b0};
					state_q <= H_M1C;
				end
				H_M1C: begin
					acc_q   <= acc_q + {prod[31:0], 32'b0};
					state_q <= H_X1;
				end
				H_X1: begin
					x_q     <= acc_mix;
					state_q <= H_M2A;
				end
				H_M2A: begin
					acc_q   <= prod;
					state_q <= H_M2B;
				end
				H_M2B: begin
					acc_q   <= acc_q + {prod[31:0], 32'b0};
					state_q <= H_M2C;
				end
				H_M2C: begin
					acc_q   <= acc_q + {prod[31:0], 32'b0};
					state_q <= H_X2;
				end
				H_X2: begin
					// The first round yields mixA; the second mixes key ^ mixA for bucket B.
					if (!pass_q) begin
						mix_a_q <= acc_mix;
						x_q     <= y_pre;
						pass_q  <= 1'b1;
						state_q <= H_M1A;
					end else begin
						x_q     <= acc_mix;
						state_q <= H_RALO;
					end
				end
				H_RALO: begin
					acc_q   <= prod;
					state_q <= H_RAHI;
				end
				H_RAHI: begin
					ba_q    <= mid[32 +: BW];
					state_q <= H_RBLO;
				end
				H_RBLO: begin
					acc_q   <= prod;
					state_q <= H_RBHI;
				end
				H_RBHI: begin
					bb_q    <= mid[32 +: BW];
					state_q <= H_ADJ;
				end
				H_ADJ: begin
					if (bb_q == ba_q) begin
						bb_q <= ba_last ? '0 : ba_q + BW'(1);
					end
					done_q  <= 1'b1;
					state_q <= H_IDLE;
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign bkt_a = ba_q;
	assign bkt_b = bb_q;

endmodule

// ===== rtl/two_choice_bucket_hash_table_unit.sv =====
// Top level of the two-choice bucket hash table.
//
// Input words arrive on s_axis: tdata holds the key and the value, tuser holds
// func and count_new. Each word yields exactly one result word on m_axis with
// the status, the looked-up value and the running entry total.
// One item is in flight at a time. After the accept the hash unit runs its
// state sequence (three 32x32 partial products per 64-bit multiply, two multiplies
// per fmix64, two fmix64 rounds, two range reductions) and hands the buckets
// over, then bucket A and bucket B are read from the key and value memories
// one row per cycle, and the decision with its write back follows. A result is
// registered with the write back, and s_axis_tready rises in that same cycle.
// After reset the key memory is swept to empty, one bucket row per cycle, with
// s_axis_tready low; the APB register is writable then.
// If the receiver stalls, the result word waits in the output register while
// the next input word is taken; that item then holds before its write back
// until the waiting word is taken.
`include "two_choice_bucket_hash_table_unit_assert.svh"

module two_choice_bucket_hash_table_unit import tcbh_pkg::*; #(
	parameter int NUM_BUCKETS  = NUM_BUCKETS_DEF,
	parameter int BUCKET_SLOTS = BUCKET_SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,   // key[63:0], value[127:64]
	input  logic [1:0]   s_axis_tuser,   // func[0], count_new[1]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [95:0]  m_axis_tdata,   // value_out[63:0], entry_total[95:64]
	output logic [2:0]   m_axis_tuser,   // status[2:0]
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int AW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int NW = $clog2(NUM_BUCKETS + 1);
	localparam int SW = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
	localparam int OW = $clog2(BUCKET_SLOTS + 1);
	localparam int RW = BUCKET_SLOTS * KEY_W;

	typedef enum logic [2:0] {T_CLR, T_IDLE, T_HASH, T_RDA, T_RDB, T_DEC} tstate_t;

	tstate_t             state_q;
	logic [AW-1:0]       clr_cnt_q;
	logic [CFG_W-1:0]    nbkt_cfg_q;
	logic [TOTAL_W-1:0]  entry_count_q;
	logic                func_q;
	logic                cnew_q;
	logic [KEY_W-1:0]    key_q;
	logic [VAL_W-1:0]    value_q;
	logic [BUCKET_SLOTS-1:0][KEY_W-1:0] rowa_q, rowb_q;
	logic [BUCKET_SLOTS-1:0][VAL_W-1:0] vala_q, valb_q;
	logic                out_valid_q;
	status_t             out_status_q;
	logic [VAL_W-1:0]    out_value_q;
	logic [TOTAL_W-1:0]  out_total_q;

	logic                in_fire;
	logic                dec_fire;
	logic [31:0]         bc32;
	logic [31:0]         n32;
	logic [NW-1:0]       n_eff;
	logic                h_done;
	logic [AW-1:0]       h_ba, h_bb;

	logic [AW-1:0]       ram_addr;
	logic                key_we, val_we;
	logic [RW-1:0]       key_wdata, key_rdata, val_rdata;

	logic [BUCKET_SLOTS-1:0] hit_a, hit_b, used_a, used_b;
	logic [SW-1:0]       sa, sb;
	logic [OW-1:0]       oa, ob;
	status_t             dec_status;
	logic [VAL_W-1:0]    dec_value;
	logic                dec_count_add;
	logic                dec_place, dec_update;
	logic [AW-1:0]       wr_bucket;
	logic [BUCKET_SLOTS-1:0][KEY_W-1:0] key_row_new;
	logic [BUCKET_SLOTS-1:0][VAL_W-1:0] val_row_new;
	logic [TOTAL_W-1:0]  count_next;
	logic                cfg_write;

	// Effective bucket count: zero acts as one, larger values saturate.
	assign bc32  = 32'(nbkt_cfg_q);
	assign n32   = (bc32 == 32'd0) ? 32'd1 :
	               ((bc32 > 32'(NUM_BUCKETS)) ? 32'(NUM_BUCKETS) : bc32);
	assign n_eff = n32[NW-1:0];

	assign s_axis_tready = (state_q == T_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign dec_fire      = (state_q == T_DEC) && (!out_valid_q || m_axis_tready);

	tcbh_hash #(.NUM_BUCKETS(NUM_BUCKETS)) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_fire),
		.key    (s_axis_tdata[63:0]),
		.n      (n_eff),
		.done   (h_done),
		.bkt_a  (h_ba),
		.bkt_b  (h_bb)
	);

	always_comb begin
		unique case (state_q)
			T_CLR:   ram_addr = clr_cnt_q;
			T_RDA:   ram_addr = h_bb;
			T_DEC:   ram_addr = wr_bucket;
			default: ram_addr = h_ba;
		endcase
	end

	assign key_we    = (state_q == T_CLR) || (dec_fire && dec_place);
	assign val_we    = dec_fire && (dec_place || dec_update);
	assign key_wdata = (state_q == T_CLR) ? '0 : RW'(key_row_new);

	tcbh_ram #(.WIDTH(RW), .DEPTH(NUM_BUCKETS)) u_key_ram (
		.clk   (clk),
		.addr  (ram_addr),
		.we    (key_we),
		.wdata (key_wdata),
		.rdata (key_rdata)
	);

	tcbh_ram #(.WIDTH(RW), .DEPTH(NUM_BUCKETS)) u_val_ram (
		.clk   (clk),
		.addr  (ram_addr),
		.we    (val_we),
		.wdata (RW'(val_row_new)),
		.rdata (val_rdata)
	);

	// Slot match, lowest matching slot and occupancy of both buckets.
	always_comb begin
		sa = '0;
		sb = '0;
		for (int s = 0; s < BUCKET_SLOTS; s++) begin
			hit_a[s]  = (rowa_q[s] == key_q);
			hit_b[s]  = (rowb_q[s] == key_q);
			used_a[s] = (rowa_q[s] != '0);
			used_b[s] = (rowb_q[s] != '0);
		end
		for (int s = BUCKET_SLOTS - 1; s >= 0; s--) begin
			if (hit_a[s]) sa = SW'(s);
			if (hit_b[s]) sb = SW'(s);
		end
		oa = OW'($countones(used_a));
		ob = OW'($countones(used_b));
	end

	always_comb begin
		dec_status    = ST_MISS;
		dec_value     = '0;
		dec_count_add = 1'b0;
		dec_place     = 1'b0;
		dec_update    = 1'b0;
		wr_bucket     = h_ba;
		key_row_new   = rowa_q;
		val_row_new   = vala_q;
		if (key_q == '0) begin
			dec_status = (func_q == FUNC_INSERT) ? ST_DROPPED : ST_MISS;
		end else if (func_q == FUNC_LOOKUP) begin
			if (|hit_a) begin
				dec_status = ST_HIT;
				dec_value  = vala_q[sa];
			end else if (|hit_b) begin
				dec_status = ST_HIT;
				dec_value  = valb_q[sb];
			end
		end else if (|hit_a) begin
			dec_status      = ST_UPDATED;
			dec_update      = 1'b1;
			val_row_new[sa] = value_q;
		end else if (|hit_b) begin
			dec_status      = ST_UPDATED;
			dec_update      = 1'b1;
			wr_bucket       = h_bb;
			val_row_new     = valb_q;
			val_row_new[sb] = value_q;
		end else begin
			// The entry count moves with count_new even when both buckets turn out to be full.
			dec_count_add = cnew_q;
			if (oa >= OW'(BUCKET_SLOTS) && ob >= OW'(BUCKET_SLOTS)) begin
				dec_status = ST_DROPPED;
			end else if (oa <= ob) begin
				dec_status              = ST_PLACED;
				dec_place               = 1'b1;
				key_row_new[oa[SW-1:0]] = key_q;
				val_row_new[oa[SW-1:0]] = value_q;
			end else begin
				dec_status              = ST_PLACED;
				dec_place               = 1'b1;
				wr_bucket               = h_bb;
				key_row_new             = rowb_q;
				val_row_new             = valb_q;
				key_row_new[ob[SW-1:0]] = key_q;
				val_row_new[ob[SW-1:0]] = value_q;
			end
		end
	end

	assign count_next = entry_count_q + TOTAL_W'(dec_count_add);
	assign cfg_write  = psel && penable && pwrite && pready && (paddr[2] == REG_NBKT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= T_CLR;
			clr_cnt_q     <= '0;
			nbkt_cfg_q    <= NBKT_RST;
			entry_count_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_write) begin
				nbkt_cfg_q <= pwdata[CFG_W-1:0];
			end
			// A new result may replace the one taken in the same cycle.
			if (dec_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				T_CLR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(NUM_BUCKETS - 1)) begin
						state_q <= T_IDLE;
					end
				end
				T_IDLE: begin
					if (in_fire) begin
						key_q   <= s_axis_tdata[63:0];
						value_q <= s_axis_tdata[127:64];
						func_q  <= s_axis_tuser[0];
						cnew_q  <= s_axis_tuser[1];
						state_q <= T_HASH;
					end
				end
				T_HASH: begin
					if (h_done) begin
						state_q <= T_RDA;
					end
				end
				T_RDA: begin
					rowa_q  <= key_rdata;
					vala_q  <= val_rdata;
					state_q <= T_RDB;
				end
				T_RDB: begin
					rowb_q  <= key_rdata;
					valb_q  <= val_rdata;
					state_q <= T_DEC;
				end
				T_DEC: begin
					if (dec_fire) begin
						entry_count_q <= count_next;
						out_status_q  <= dec_status;
						out_value_q   <= dec_value;
						out_total_q   <= count_next;
						state_q       <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_total_q, out_value_q};
	assign m_axis_tuser  = out_status_q;
	assign pready        = 1'b1;
	assign prdata        = (paddr[2] == REG_NBKT) ? 32'(nbkt_cfg_q) : 32'd0;

	`TCBH_ASSERT_NEXT(a_one_in_flight, clk, arst_n,
		s_axis_tvalid && s_axis_tready, !s_axis_tready,
		"input word accepted while an item is in flight")
	`TCBH_ASSERT_SAME(a_value_only_on_hit, clk, arst_n,
		m_axis_tvalid && out_value_q != '0, out_status_q == ST_HIT,
		"nonzero value on a result that is not a hit")
	`TCBH_ASSERT_SAME(a_key_write_insert, clk, arst_n,
		key_we && state_q != T_CLR, func_q == FUNC_INSERT && key_q != '0,
		"key row written outside an insert")

endmodule

// ===== sim/two_choice_bucket_hash_table_unit_tb.sv =====
// Self-checking testbench of the two-choice bucket hash table unit.
`timescale 1ns / 1ps

class hash_table_scoreboard;
	typedef struct {
		tcbh_pkg::status_t status;
		logic [63:0]       value_out;
		logic [31:0]       entry_total;
	} table_result_t;

	localparam int DEPTH = tcbh_pkg::NUM_BUCKETS_DEF * tcbh_pkg::BUCKET_SLOTS_DEF;
	localparam int SLOTS = tcbh_pkg::BUCKET_SLOTS_DEF;

	logic [63:0]   keys [DEPTH];
	logic [63:0]   values [DEPTH];
	logic [31:0]   entries;
	logic [8:0]    nbkt_cfg;
	table_result_t pending_results [$];
	int            mismatches;

	function new();
		foreach (keys[i]) begin
			keys[i] = '0;
			values[i] = '0;
		end
		entries = '0;
		nbkt_cfg = tcbh_pkg::NBKT_RST;
		mismatches = 0;
	endfunction

	function void set_nbkt_cfg(logic [31:0] wdata);
		nbkt_cfg = wdata[8:0];
	endfunction

	function logic [63:0] fmix(logic [63:0] h);
		h = h ^ (h >> tcbh_pkg::FMIX_SHIFT);
		h = h * tcbh_pkg::FMIX_C1;
		h = h ^ (h >> tcbh_pkg::FMIX_SHIFT);
		h = h * tcbh_pkg::FMIX_C2;
		h = h ^ (h >> tcbh_pkg::FMIX_SHIFT);
		return h;
	endfunction

	// High half of the 128-bit product x * n.
	function int unsigned reduce_to_bucket(logic [63:0] x, int unsigned n);
		logic [127:0] p;
		p = {64'd0, x} * {96'd0, n};
		return int'(p[127:64]);
	endfunction

	function int find_slot(int unsigned bucket, logic [63:0] key);
		for (int s = 0; s < SLOTS; s++)
			if (keys[bucket * SLOTS + s] == key)
				return s;
		return -1;
	endfunction

	function int unsigned occupied(int unsigned bucket);
		int unsigned c;
		c = 0;
		for (int s = 0; s < SLOTS; s++)
			if (keys[bucket * SLOTS + s] != 0)
				c++;
		return c;
	endfunction

	function void note_request(bit func, logic [63:0] key, logic [63:0] val, bit cnew);
		int unsigned   n, ba, bb, oa, ob, fb, fo;
		int            sa, sb;
		logic [63:0]   mix_a;
		table_result_t r;
		n = nbkt_cfg;
		if (n == 0)
			n = 1;
		if (n > tcbh_pkg::NUM_BUCKETS_DEF)
			n = tcbh_pkg::NUM_BUCKETS_DEF;
		mix_a = fmix(key);
		ba = reduce_to_bucket(mix_a, n);
		bb = reduce_to_bucket(fmix(key ^ mix_a), n);
		if (bb == ba)
			bb = (ba == n - 1) ? 0 : ba + 1;
		r.status = tcbh_pkg::ST_MISS;
		r.value_out = '0;
		if (key == 0) begin
			r.status = (func == tcbh_pkg::FUNC_INSERT) ? tcbh_pkg::ST_DROPPED
				: tcbh_pkg::ST_MISS;
		end else begin
			sa = find_slot(ba, key);
			sb = (sa < 0) ? find_slot(bb, key) : -1;
			if (func == tcbh_pkg::FUNC_LOOKUP) begin
				if (sa >= 0) begin
					r.status = tcbh_pkg::ST_HIT;
					r.value_out = values[ba * SLOTS + sa];
				end else if (sb >= 0) begin
					r.status = tcbh_pkg::ST_HIT;
					r.value_out = values[bb * SLOTS + sb];
				end
			end else if (sa >= 0) begin
				values[ba * SLOTS + sa] = val;
				r.status = tcbh_pkg::ST_UPDATED;
			end else if (sb >= 0) begin
				values[bb * SLOTS + sb] = val;
				r.status = tcbh_pkg::ST_UPDATED;
			end else begin
				oa = occupied(ba);
				ob = occupied(bb);
				// The count is taken before placement, so a drop still counts.
				entries = entries + cnew;
				if (oa >= SLOTS && ob >= SLOTS) begin
					r.status = tcbh_pkg::ST_DROPPED;
				end else begin
					fb = (oa <= ob) ? ba : bb;
					fo = (oa <= ob) ? oa : ob;
					keys[fb * SLOTS + fo] = key;
					values[fb * SLOTS + fo] = val;
					r.status = tcbh_pkg::ST_PLACED;
				end
			end
		end
		r.entry_total = entries;
		pending_results.push_back(r);
	endfunction

	task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH %s: got %h, want %h", what, got, want);
		mismatches++;
	endtask

	task check_result(logic [2:0] status, logic [63:0] vout, logic [31:0] total);
		table_result_t w;
		if (pending_results.size() == 0) begin
			report_mismatch("unexpected word", {61'd0, status}, 64'd0);
			return;
		end
		w = pending_results.pop_front();
		if (status !== w.status)
			report_mismatch("status", {61'd0, status}, {61'd0, w.status});
		if (vout !== w.value_out)
			report_mismatch("value_out", vout, w.value_out);
		if (total !== w.entry_total)
			report_mismatch("entry_total", {32'd0, total}, {32'd0, w.entry_total});
	endtask
endclass

module two_choice_bucket_hash_table_unit_tb import tcbh_pkg::*; ();

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;   // key[63:0], value[127:64]
	logic [1:0]   s_axis_tuser;   // func[0], count_new[1]
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [95:0]  m_axis_tdata;   // value_out[63:0], entry_total[95:64]
	logic [2:0]   m_axis_tuser;   // status[2:0]
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	hash_table_scoreboard table_sb;
	logic [63:0]          key_pool [$];
	int                   burst_left;
	int                   rx_left;
	int                   rx_mode;

	two_choice_bucket_hash_table_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("two_choice_bucket_hash_table_unit test failed");
		$finish;
	end

	// Receiver: stretches of random length that stall, toggle ready at random, or stay ready.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(1, 30);
		end
		rx_left--;
		case (rx_mode)
			0: m_axis_tready = 1'b0;
			1: m_axis_tready = 1'($urandom_range(0, 1));
			default: m_axis_tready = 1'b1;
		endcase
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			table_sb.check_result(m_axis_tuser, m_axis_tdata[63:0], m_axis_tdata[95:64]);

	task automatic wait_drained();
		while (table_sb.pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_nbkt_cfg(logic [31:0] wdata);
		wait_drained();
		repeat (30) @(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = 3'(REG_NBKT) << 2;
		pwdata = wdata;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		table_sb.set_nbkt_cfg(wdata);
		@(negedge clk);
		if (prdata !== {23'd0, wdata[8:0]})
			table_sb.report_mismatch("prdata", {32'd0, prdata}, {55'd0, wdata[8:0]});
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Drives one word and returns after its accept edge; gaps fall between bursts.
	task automatic send_word(bit func, logic [63:0] key, logic [63:0] val, bit cnew);
		if (burst_left == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40))
				@(negedge clk);
			burst_left = $urandom_range(1, 8);
		end
		burst_left--;
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {val, key};
		s_axis_tuser = {cnew, func};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		table_sb.note_request(func, key, val, cnew);
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic random_phase(int count);
		int          pick;
		logic [63:0] key;
		bit          func;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 60 && key_pool.size() != 0)
				key = key_pool[$urandom_range(0, key_pool.size() - 1)];
			else if (pick < 95)
				key = rand64();
			else if (pick < 97)
				key = '0;
			else if (pick < 99)
				key = '1;
			else
				key = 64'd1;
			func = 1'($urandom_range(0, 1));
			if (func == FUNC_INSERT && key != 0)
				key_pool.push_back(key);
			send_word(func, key, rand64(), 1'($urandom_range(0, 1)));
			if (i == count / 2) begin
				s_axis_tvalid = 1'b0;
				wait_drained();
			end
		end
		s_axis_tvalid = 1'b0;
	endtask

	initial begin
		table_sb = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		burst_left = 0;
		rx_left = 0;
		rx_mode = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// Directed: reserved key, extremes, hit, update, miss.
		send_word(FUNC_LOOKUP, 64'd0, '1, 1'b1);
		send_word(FUNC_INSERT, 64'd0, '1, 1'b1);
		send_word(FUNC_INSERT, '1, '1, 1'b1);
		send_word(FUNC_LOOKUP, '1, '0, 1'b0);
		send_word(FUNC_INSERT, '1, '0, 1'b1);
		send_word(FUNC_LOOKUP, '1, '1, 1'b1);
		send_word(FUNC_INSERT, 64'd1, 64'h5555_AAAA_5555_AAAA, 1'b0);
		send_word(FUNC_LOOKUP, 64'd1, '0, 1'b0);
		send_word(FUNC_LOOKUP, 64'h8000_0000_0000_0000, '0, 1'b0);
		key_pool.push_back('1);
		key_pool.push_back(64'd1);
		s_axis_tvalid = 1'b0;

		// Single bucket: fills at once, then drops still count.
		write_nbkt_cfg(32'd1);
		for (int i = 0; i < 7; i++)
			send_word(FUNC_INSERT, rand64(), rand64(), 1'b1);
		send_word(FUNC_LOOKUP, '1, '0, 1'b0);
		s_axis_tvalid = 1'b0;
		random_phase(60);

		write_nbkt_cfg(32'd2);
		random_phase(150);
		write_nbkt_cfg(32'd256);
		random_phase(400);
		write_nbkt_cfg(32'd0);
		random_phase(80);
		write_nbkt_cfg(32'd511);
		random_phase(300);
		write_nbkt_cfg(32'd17);
		random_phase(250);
		write_nbkt_cfg(32'd255);
		random_phase(300);
		write_nbkt_cfg(32'd300);
		random_phase(250);

		wait_drained();
		repeat (40) @(negedge clk);
		if (table_sb.mismatches == 0)
			$display("two_choice_bucket_hash_table_unit test passed");
		else
			$display("two_choice_bucket_hash_table_unit test failed");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tcbh_pkg.sv
rtl/tcbh_ram.sv
rtl/tcbh_hash.sv
rtl/two_choice_bucket_hash_table_unit.sv
sim/two_choice_bucket_hash_table_unit_tb.sv
